>>> rtl/olie_pkg.sv
// Shared types and constants for the ordered list block.
// Used by olie_ctrl, olie_cell and ordered_list_insert_erase; depends on nothing.
`default_nettype none

package olie_pkg;

   // Index and count width inside the cell row, enough for the largest supported capacity.
   localparam int IDX_W = 9;

   typedef enum logic [2:0] {
      REQ_APPEND      = 3'd0,
      REQ_REMOVE_LAST = 3'd1,
      REQ_INSERT      = 3'd2,
      REQ_ERASE       = 3'd3,
      REQ_CLEAR       = 3'd4
   } req_op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_BAD_POS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD   = 2'd0,
      SHIFT_INSERT = 2'd1,
      SHIFT_ERASE  = 2'd2
   } shift_op_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      shift_op_type     op;
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] count;
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
   } cell_cmd_type;

endpackage

`default_nettype wire

>>> rtl/olie_cell.sv
// One storage cell of the ordered list row.
// Depends on olie_pkg; instantiated once per entry by ordered_list_insert_erase.
`default_nettype none

module olie_cell
   import olie_pkg::*;
#(
   parameter int INDEX      = 0,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire cell_cmd_type          cmd,
   input  wire logic [DATA_WIDTH-1:0] new_value,
   input  wire logic [DATA_WIDTH-1:0] left_data,
   input  wire logic [DATA_WIDTH-1:0] right_data,
   output logic      [DATA_WIDTH-1:0] entry,
   output logic      [DATA_WIDTH-1:0] tap
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         SHIFT_INSERT: begin
            // The target cell takes the new item; cells above it up to the old count move up.
            if (MY_IDX == cmd.pos) begin
               entry_in = new_value;
            end else if (MY_IDX > cmd.pos && MY_IDX <= cmd.count) begin
               entry_in = left_data;
            end
         end
         SHIFT_ERASE: begin
            if (MY_IDX >= cmd.pos && (MY_IDX + 1'b1) < cmd.count) begin
               entry_in = right_data;
            end
         end
         SHIFT_HOLD: begin
            entry_in = entry_ff;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign tap   = (cmd.rd_en && MY_IDX == cmd.rd_idx) ? entry_ff : '0;

endmodule

`default_nettype wire

>>> rtl/olie_ctrl.sv
// Count register and request decode for the ordered list.
// Depends on olie_pkg; drives the command that all cells share.
`default_nettype none

module olie_ctrl
   import olie_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int CNT_W    = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [2:0]       req_type,
   input  wire logic [4:0]       req_position,
   output cell_cmd_type          cmd,
   output status_type            status,
   output logic      [CNT_W-1:0] count_next
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic [IDX_W-1:0] count_x;
   logic [IDX_W-1:0] pos_x;
   logic [IDX_W-1:0] cap_x;
   logic [IDX_W-1:0] count_new;
   cell_cmd_type     cmd_dec;

   assign count_x = IDX_W'(count_ff);
   assign pos_x   = IDX_W'(req_position);
   assign cap_x   = IDX_W'(CAPACITY);

   always_comb begin
      status         = ST_OK;
      count_new      = count_x;
      cmd_dec.op     = SHIFT_HOLD;
      cmd_dec.pos    = pos_x;
      cmd_dec.count  = count_x;
      cmd_dec.rd_en  = 1'b0;
      cmd_dec.rd_idx = count_x - 1'b1;
      unique case (req_op_type'(req_type))
         REQ_APPEND: begin
            if (count_x >= cap_x) begin
               status = ST_FULL;
            end else begin
               // An append is an insert at the current end of the list.
               cmd_dec.op  = SHIFT_INSERT;
               cmd_dec.pos = count_x;
               count_new   = count_x + 1'b1;
            end
         end
         REQ_REMOVE_LAST: begin
            if (count_x == '0) begin
               status = ST_EMPTY;
            end else begin
               cmd_dec.rd_en = 1'b1;
               count_new     = count_x - 1'b1;
            end
         end
         REQ_INSERT: begin
            if (pos_x > count_x) begin
               status = ST_BAD_POS;
            end else if (count_x >= cap_x) begin
               status = ST_FULL;
            end else begin
               cmd_dec.op = SHIFT_INSERT;
               count_new  = count_x + 1'b1;
            end
         end
         REQ_ERASE: begin
            if (count_x == '0) begin
               status = ST_EMPTY;
            end else if (pos_x >= count_x) begin
               status = ST_BAD_POS;
            end else begin
               cmd_dec.op     = SHIFT_ERASE;
               cmd_dec.rd_en  = 1'b1;
               cmd_dec.rd_idx = pos_x;
               count_new      = count_x - 1'b1;
            end
         end
         REQ_CLEAR: begin
            count_new = '0;
         end
         default: begin
            count_new = count_x;
         end
      endcase
   end

   always_comb begin
      cmd = cmd_dec;
      if (!accept) begin
         cmd.op = SHIFT_HOLD;
      end
   end

   assign count_next = CNT_W'(count_new);
   assign count_in   = accept ? count_next : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_x <= cap_x)
      else $error("entry count exceeds capacity");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && req_type == REQ_CLEAR |=> count_ff == '0)
      else $error("clear did not empty the list");

   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      accept && status != ST_OK |=> count_ff == $past(count_ff))
      else $error("rejected item changed the entry count");

endmodule

`default_nettype wire

>>> rtl/ordered_list_insert_erase.sv
// Ordered list with insert, erase, append, remove-last and clear.
// The list is a row of cells; the affected cells shift at once on insert or erase.
// The block takes one item per clock cycle as long as the result side keeps up;
// each result appears in the output register in the cycle after its item is
// accepted. Insert and erase move every affected cell to its neighbor in that
// same cycle, and the removed value is picked from the cells before the shift.
// Depends on olie_pkg, olie_ctrl and olie_cell.
`default_nettype none

module ordered_list_insert_erase
   import olie_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [4:0]  req_position,
   input  wire logic [31:0] req_entry_value,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_entry_count,
   output logic             rsp_is_empty,
   output logic [31:0]      rsp_removed_value
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                  accept;
   cell_cmd_type          cmd;
   status_type            status;
   logic [CNT_W-1:0]      count_next;
   logic [DATA_WIDTH-1:0] new_value;
   logic [DATA_WIDTH-1:0] entry [CAPACITY];
   logic [DATA_WIDTH-1:0] tap   [CAPACITY];
   logic [DATA_WIDTH-1:0] removed;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [1:0]  status_ff;
   logic [4:0]  count_ff;
   logic        empty_ff;
   logic [31:0] removed_ff;

   // A new item may enter whenever the output register is free or being emptied,
   // and never while reset is held.
   assign req_stall = reset || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign new_value = DATA_WIDTH'(req_entry_value);

   olie_ctrl #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_type     (req_type),
      .req_position (req_position),
      .cmd          (cmd),
      .status       (status),
      .count_next   (count_next)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = entry[i+1];
      end

      olie_cell #(
         .INDEX      (i),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .new_value  (new_value),
         .left_data  (left_data),
         .right_data (right_data),
         .entry      (entry[i]),
         .tap        (tap[i])
      );
   end

   // At most one cell drives a nonzero tap, so an OR gathers the removed entry.
   always_comb begin
      removed = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         removed = removed | tap[i];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status;
         count_ff   <= 5'(count_next);
         empty_ff   <= (count_next == '0);
         removed_ff <= 32'(removed);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_entry_count   = count_ff;
   assign rsp_is_empty      = empty_ff;
   assign rsp_removed_value = removed_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_removed_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status != ST_OK |-> rsp_removed_value == '0)
      else $error("failed item reported a removed value");

   a_empty_status_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status == ST_EMPTY |-> rsp_is_empty)
      else $error("empty status on a list that holds entries");

endmodule

`default_nettype wire
